[rtl/wtg_pkg.sv]
// Shared constants and helpers for the weighted three-table gshare predictor.
package wtg_pkg;

  // Default sizes
  localparam int TABLE_ENTRIES_DEF   = 16384;
  localparam int COUNTER_BITS_DEF    = 2;
  localparam int SHORT_HIST_LEN_DEF  = 8;
  localparam int MEDIUM_HIST_LEN_DEF = 16;
  localparam int LONG_HIST_LEN_DEF   = 32;

  // Fixed field widths
  localparam int ADDR_W   = 64;
  localparam int WEIGHT_W = 3;
  localparam int SCORE_W  = 5;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 3'd7;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 3'd4;

  // Command codes
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  typedef logic [WEIGHT_W-1:0] weight_t;

  // Step a weight toward agreement, clamped to 0..WEIGHT_MAX
  function automatic weight_t train_weight(input weight_t w, input logic hit);
    weight_t r;
    if (hit) begin
      r = (w == WEIGHT_MAX) ? w : w + 3'd1;
    end else begin
      r = (w == 3'd0) ? w : w - 3'd1;
    end
    return r;
  endfunction

endpackage

[rtl/weighted_three_table_gshare.sv]
// Weighted three-table gshare branch direction predictor, top level.
//
// Input channel (in_valid/in_ready) carries command, branch_addr and
// outcome_taken. A predict item yields one result on the output channel
// (out_valid/out_ready, predict_taken); an update item yields none and
// trains the three counter tables, the three weights and the histories.
// The three tables sit in single-port synchronous memories with a registered
// read. An item is read in its accept cycle and finished (result loaded or
// counters written back) in the execute state that follows, where a predict
// item waits while the output register is full and not taken. A new item is
// taken only once the last is finished: only one item is in flight, so a
// write-back always lands before the next read and no forwarding is
// needed.
// At reset the block sweeps all three tables to zero, one entry per cycle,
// with in_ready low; histories clear and the weights start at four. While
// the receiver stalls, a finished prediction holds in the output register and
// a following predict item waits. The user keeps TABLE_ENTRIES a power of two;
// the block does not check it. Index: low bits of address XOR history.
module weighted_three_table_gshare #(
  parameter int TABLE_ENTRIES   = wtg_pkg::TABLE_ENTRIES_DEF,
  parameter int COUNTER_BITS    = wtg_pkg::COUNTER_BITS_DEF,
  parameter int SHORT_HIST_LEN  = wtg_pkg::SHORT_HIST_LEN_DEF,
  parameter int MEDIUM_HIST_LEN = wtg_pkg::MEDIUM_HIST_LEN_DEF,
  parameter int LONG_HIST_LEN   = wtg_pkg::LONG_HIST_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic [wtg_pkg::ADDR_W-1:0] branch_addr,
  input  logic                      outcome_taken,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      predict_taken
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CB     = COUNTER_BITS;
  localparam int CMAX_I = (1 << CB) - 1;
  localparam logic [CB-1:0] CMAX    = CB'(CMAX_I);
  localparam logic [CB-1:0] THRESH  = CB'(CMAX_I / 2);
  localparam logic [CB-1:0] CNT_ONE = CB'(1);

  // State codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [IDX_W-1:0] clr_idx;

  logic [SHORT_HIST_LEN-1:0]  short_hist;
  logic [MEDIUM_HIST_LEN-1:0] medium_hist;
  logic [LONG_HIST_LEN-1:0]   long_hist;
  wtg_pkg::weight_t short_w, medium_w, long_w;

  logic [CB-1:0] short_mem  [TABLE_ENTRIES];
  logic [CB-1:0] medium_mem [TABLE_ENTRIES];
  logic [CB-1:0] long_mem   [TABLE_ENTRIES];
  logic [CB-1:0] short_rd, medium_rd, long_rd;

  logic [IDX_W-1:0] idx_short, idx_medium, idx_long;
  logic             cmd_hold, outcome_hold;

  logic accept;
  logic [wtg_pkg::ADDR_W-1:0] hash_short, hash_medium, hash_long;
  logic [IDX_W-1:0] rd_short, rd_medium, rd_long;
  logic [CB-1:0] short_next, medium_next, long_next;
  logic [wtg_pkg::SCORE_W-1:0] score, wsum;
  logic pred;
  logic load_out;
  logic do_update;
  logic wr_en;
  logic [IDX_W-1:0] wr_short, wr_medium, wr_long;
  logic [CB-1:0] wd_short, wd_medium, wd_long;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Hash the address with each history
  assign hash_short  = branch_addr ^ wtg_pkg::ADDR_W'(short_hist);
  assign hash_medium = branch_addr ^ wtg_pkg::ADDR_W'(medium_hist);
  assign hash_long   = branch_addr ^ wtg_pkg::ADDR_W'(long_hist);
  assign rd_short  = hash_short[IDX_W-1:0];
  assign rd_medium = hash_medium[IDX_W-1:0];
  assign rd_long   = hash_long[IDX_W-1:0];

  // Saturate each read counter toward the outcome
  always_comb begin
    if (outcome_hold) begin
      short_next  = (short_rd  == CMAX) ? short_rd  : short_rd  + CNT_ONE;
      medium_next = (medium_rd == CMAX) ? medium_rd : medium_rd + CNT_ONE;
      long_next   = (long_rd   == CMAX) ? long_rd   : long_rd   + CNT_ONE;
    end else begin
      short_next  = (short_rd  == '0) ? short_rd  : short_rd  - CNT_ONE;
      medium_next = (medium_rd == '0) ? medium_rd : medium_rd - CNT_ONE;
      long_next   = (long_rd   == '0) ? long_rd   : long_rd   - CNT_ONE;
    end
  end

  // Weighted vote over the read counters
  always_comb begin
    score = ((short_rd  >= THRESH) ? wtg_pkg::SCORE_W'(short_w)  : '0)
          + ((medium_rd >= THRESH) ? wtg_pkg::SCORE_W'(medium_w) : '0)
          + ((long_rd   >= THRESH) ? wtg_pkg::SCORE_W'(long_w)   : '0);
    wsum  = wtg_pkg::SCORE_W'(short_w) + wtg_pkg::SCORE_W'(medium_w)
          + wtg_pkg::SCORE_W'(long_w);
    pred  = (score >= (wsum >> 1));
  end

  assign do_update = (state == ST_EXEC) && (cmd_hold == wtg_pkg::CMD_UPDATE);
  assign load_out  = (state == ST_EXEC) && (cmd_hold == wtg_pkg::CMD_PREDICT)
                   && (!out_valid || out_ready);

  // Select the memory write: clearing sweep or training write-back
  always_comb begin
    wr_en = (state == ST_CLEAR) || do_update;
    if (state == ST_CLEAR) begin
      wr_short  = clr_idx;
      wr_medium = clr_idx;
      wr_long   = clr_idx;
      wd_short  = '0;
      wd_medium = '0;
      wd_long   = '0;
    end else begin
      wr_short  = idx_short;
      wr_medium = idx_medium;
      wr_long   = idx_long;
      wd_short  = short_next;
      wd_medium = medium_next;
      wd_long   = long_next;
    end
  end

  // Counter tables
  always_ff @(posedge clk) begin
    if (wr_en) begin
      short_mem[wr_short] <= wd_short;
    end
    if (accept) begin
      short_rd <= short_mem[rd_short];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      medium_mem[wr_medium] <= wd_medium;
    end
    if (accept) begin
      medium_rd <= medium_mem[rd_medium];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      long_mem[wr_long] <= wd_long;
    end
    if (accept) begin
      long_rd <= long_mem[rd_long];
    end
  end

  // Hold the accepted item for the execute state
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_short    <= rd_short;
      idx_medium   <= rd_medium;
      idx_long     <= rd_long;
      cmd_hold     <= command;
      outcome_hold <= outcome_taken;
    end
  end

  // Sequence clear, idle and execute
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == '1) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC:  if (do_update || load_out) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  // Train weights and shift histories on update
  always_ff @(posedge clk) begin
    if (rst) begin
      short_hist  <= '0;
      medium_hist <= '0;
      long_hist   <= '0;
      short_w     <= wtg_pkg::WEIGHT_RESET;
      medium_w    <= wtg_pkg::WEIGHT_RESET;
      long_w      <= wtg_pkg::WEIGHT_RESET;
    end else if (do_update) begin
      short_w  <= wtg_pkg::train_weight(short_w, (short_next >= THRESH) == outcome_hold);
      medium_w <= wtg_pkg::train_weight(medium_w, (medium_next >= THRESH) == outcome_hold);
      long_w   <= wtg_pkg::train_weight(long_w, (long_next >= THRESH) == outcome_hold);
      short_hist  <= SHORT_HIST_LEN'({short_hist, outcome_hold});
      medium_hist <= MEDIUM_HIST_LEN'({medium_hist, outcome_hold});
      long_hist   <= LONG_HIST_LEN'({long_hist, outcome_hold});
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      predict_taken <= pred;
    end
  end

  // One item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("item accepted while another is in flight");

  // No item taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("input ready during table clear");

  // An update never produces a result
  a_update_silent: assert property (@(posedge clk) disable iff (rst)
    do_update |=> (out_valid == $past(out_valid && !out_ready)))
    else $error("update item produced a result");

  // A finished update returns to idle right away
  a_update_done: assert property (@(posedge clk) disable iff (rst)
    do_update |=> (state == ST_IDLE))
    else $error("update did not complete in one execute cycle");

endmodule

[test/weighted_three_table_gshare_tb.sv]
// Self-checking testbench for the weighted three-table gshare predictor.
`timescale 1ns / 1ps

module weighted_three_table_gshare_tb;

  import wtg_pkg::*;

  localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int IDX_W     = $clog2(N_ENTRIES);
  localparam int CTR_W     = COUNTER_BITS_DEF;
  localparam int CTR_MAX   = (1 << CTR_W) - 1;
  localparam int SH_W      = SHORT_HIST_LEN_DEF;
  localparam int MH_W      = MEDIUM_HIST_LEN_DEF;
  localparam int LH_W      = LONG_HIST_LEN_DEF;
  localparam int POOL      = 12;

  typedef enum int {BR_ALWAYS, BR_NEVER, BR_LOOP, BR_RANDOM} branch_kind_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = CMD_PREDICT;
  logic [ADDR_W-1:0] branch_addr = '0;
  logic              outcome_taken = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              predict_taken;

  // Mirror of the predictor state
  logic [CTR_W-1:0] short_ctr  [N_ENTRIES];
  logic [CTR_W-1:0] medium_ctr [N_ENTRIES];
  logic [CTR_W-1:0] long_ctr   [N_ENTRIES];
  logic [SH_W-1:0]  short_hist;
  logic [MH_W-1:0]  medium_hist;
  logic [LH_W-1:0]  long_hist;
  weight_t          short_w, medium_w, long_w;

  logic expected_taken_q[$];
  bit   failed = 1'b0;
  bit   idle_on = 1'b1;
  int   stall_left = 0;

  // Synthetic branch population for the random part
  logic [ADDR_W-1:0] pool_addr   [POOL];
  branch_kind_e      pool_kind   [POOL];
  int                pool_period [POOL];
  int                pool_iter   [POOL];
  int                pool_bias   [POOL];

  weighted_three_table_gshare i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .branch_addr   (branch_addr),
    .outcome_taken (outcome_taken),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .predict_taken (predict_taken)
  );

  always #5 clk = ~clk;

  function automatic logic [IDX_W-1:0] index_of(input logic [ADDR_W-1:0] addr,
                                                input logic [63:0] hist);
    return IDX_W'((addr ^ hist) % N_ENTRIES);
  endfunction

  function automatic logic vote_of(input logic [CTR_W-1:0] c);
    return (int'(c) >= CTR_MAX / 2);
  endfunction

  function automatic weight_t step_weight(input weight_t w, input logic agree);
    if (agree) return (w == WEIGHT_MAX) ? w : w + 3'd1;
    return (w == 3'd0) ? w : w - 3'd1;
  endfunction

  function automatic logic [CTR_W-1:0] step_counter(input logic [CTR_W-1:0] c,
                                                   input logic taken);
    if (taken) return (int'(c) == CTR_MAX) ? c : c + 1'b1;
    return (c == '0) ? c : c - 1'b1;
  endfunction

  // Weighted vote over the three tables
  function automatic logic predict_direction(input logic [ADDR_W-1:0] addr);
    int unsigned score, sum;
    score = 0;
    if (vote_of(short_ctr[index_of(addr, 64'(short_hist))])) score += short_w;
    if (vote_of(medium_ctr[index_of(addr, 64'(medium_hist))])) score += medium_w;
    if (vote_of(long_ctr[index_of(addr, 64'(long_hist))])) score += long_w;
    sum = short_w + medium_w + long_w;
    return (score >= sum / 2);
  endfunction

  // Train counters, then weights on post-update votes, then shift histories
  task automatic train_mirror(input logic [ADDR_W-1:0] addr, input logic taken);
    logic [IDX_W-1:0] is, im, il;
    is = index_of(addr, 64'(short_hist));
    im = index_of(addr, 64'(medium_hist));
    il = index_of(addr, 64'(long_hist));
    short_ctr[is]  = step_counter(short_ctr[is], taken);
    medium_ctr[im] = step_counter(medium_ctr[im], taken);
    long_ctr[il]   = step_counter(long_ctr[il], taken);
    short_w  = step_weight(short_w, vote_of(short_ctr[is]) == taken);
    medium_w = step_weight(medium_w, vote_of(medium_ctr[im]) == taken);
    long_w   = step_weight(long_w, vote_of(long_ctr[il]) == taken);
    short_hist  = {short_hist[SH_W-2:0], taken};
    medium_hist = {medium_hist[MH_W-2:0], taken};
    long_hist   = {long_hist[LH_W-2:0], taken};
  endtask

  // Address that lands on a chosen short-table entry under the current history
  function automatic logic [ADDR_W-1:0] aim_short(input logic [IDX_W-1:0] entry);
    logic [ADDR_W-1:0] a;
    a = {$urandom, $urandom};
    a[IDX_W-1:0] = entry ^ IDX_W'(short_hist);
    return a;
  endfunction

  // Offer one item, hold it until accepted, then update the mirror
  task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                           input logic taken);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    branch_addr   <= addr;
    outcome_taken <= taken;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_PREDICT) begin
      expected_taken_q.push_back(predict_direction(addr));
    end else begin
      train_mirror(addr, taken);
    end
  endtask

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 8) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && out_ready) begin
      if (expected_taken_q.size() == 0) begin
        $error("predict_taken: expected none, actual %0b", predict_taken);
        failed = 1'b1;
      end else begin
        want = expected_taken_q.pop_front();
        if (predict_taken !== want) begin
          $error("predict_taken: expected %0b, actual %0b", want, predict_taken);
          failed = 1'b1;
        end
      end
    end
  end

  // Predict on cold tables at address extremes, with one update between; outcome ignored on predict
  task automatic test_cold_predict();
    send_item(CMD_PREDICT, '0, 1'b1);
    send_item(CMD_PREDICT, '1, 1'b0);
    send_item(CMD_PREDICT, 64'hAAAA_5555_AAAA_5555, 1'b1);
    send_item(CMD_UPDATE, '1, 1'b0);
    send_item(CMD_PREDICT, 64'h5555_AAAA_5555_AAAA, 1'b0);
  endtask

  // Drive counters to the ceiling, weights to 7, then the short weight to 0
  task automatic test_saturation_and_weights();
    logic [IDX_W-1:0] tgt [4];
    for (int i = 0; i < 4; i++) tgt[i] = IDX_W'(i * (N_ENTRIES / 4) + $urandom_range(0, 255));
    for (int i = 0; i < 4; i++) begin
      repeat ((i == 0) ? 4 : 3) send_item(CMD_UPDATE, aim_short(tgt[i]), 1'b1);
    end
    send_item(CMD_PREDICT, aim_short(tgt[0]), 1'b0);
    // Each entry steps 3->2->1 against a not-taken outcome
    for (int i = 0; i < 4; i++) begin
      repeat (2) send_item(CMD_UPDATE, aim_short(tgt[i]), 1'b0);
    end
    send_item(CMD_PREDICT, aim_short(tgt[1]), 1'b1);
  endtask

  // Interleave predict/update pairs from the branch pool with noise items
  task automatic run_branch_mix(input int n_items);
    int sent, b;
    logic tk;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        b = $urandom_range(0, POOL - 1);
        case (pool_kind[b])
          BR_ALWAYS: tk = 1'b1;
          BR_NEVER:  tk = 1'b0;
          BR_LOOP: begin
            tk = (pool_iter[b] != pool_period[b] - 1);
            pool_iter[b] = (pool_iter[b] + 1) % pool_period[b];
          end
          default:   tk = ($urandom_range(0, 99) < pool_bias[b]);
        endcase
        send_item(CMD_PREDICT, pool_addr[b], 1'($urandom_range(0, 1)));
        sent++;
        if ($urandom_range(0, 9) != 0) begin
          send_item(CMD_UPDATE, pool_addr[b], tk);
          sent++;
        end
      end else begin
        send_item(1'($urandom_range(0, 1)), {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  task automatic test_branch_mix();
    for (int i = 0; i < POOL; i++) begin
      pool_addr[i]   = {$urandom, $urandom};
      pool_kind[i]   = branch_kind_e'($urandom_range(0, 3));
      pool_period[i] = $urandom_range(2, 9);
      pool_iter[i]   = 0;
      pool_bias[i]   = $urandom_range(10, 90);
    end
    run_branch_mix(1100);
  endtask

  // No input gaps and no result stalls from the bench
  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_branch_mix(400);
  endtask

  initial begin
    for (int i = 0; i < N_ENTRIES; i++) begin
      short_ctr[i]  = '0;
      medium_ctr[i] = '0;
      long_ctr[i]   = '0;
    end
    short_hist  = '0;
    medium_hist = '0;
    long_hist   = '0;
    short_w     = WEIGHT_RESET;
    medium_w    = WEIGHT_RESET;
    long_w      = WEIGHT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_cold_predict();
    test_saturation_and_weights();
    test_branch_mix();
    test_back_to_back();
    in_valid <= 1'b0;
    while (expected_taken_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
